@@ design/fgr_pkg.sv @@
// ----------------------------------------------------------------------------
// fgr_pkg
// Shared types and fixed constants of the grouped, rounded FIR filter.
// ----------------------------------------------------------------------------
package fgr_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int TAP_INDEX_W = 9;
	localparam int ACC_W       = 32;
	localparam int GROUP_LOG   = 3;
	localparam int PART_SHIFT  = 6;
	localparam int OUT_SHIFT   = 9;
	localparam int DRAIN_CYCLES = 3;

	localparam logic [ACC_W-1:0] ACC_INIT  = ACC_W'(1 << 10);
	localparam logic [ACC_W-1:0] ROUND_ADD = ACC_W'(1 << 7);

	typedef enum logic {
		REQ_SAMPLE = 1'b0,
		REQ_COEF   = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_LOAD
	} seq_state_t;

	// sequencer to datapath control
	typedef struct packed {
		logic start;
		logic load;
		logic valid;
		logic odd;
		logic group_end;
		logic hist_ok;
	} mac_ctl_t;

endpackage

@@ design/fgr_ram.sv @@
// ----------------------------------------------------------------------------
// fgr_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module fgr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 496
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ design/fgr_ctrl.sv @@
// ----------------------------------------------------------------------------
// fgr_ctrl
// Sequencer: accepts transactions, walks all taps once per sample and keeps
// the circular history pointers and fill count.
// ----------------------------------------------------------------------------
module fgr_ctrl
	import fgr_pkg::*;
#(
	parameter int TAPS = 496
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_stall,
	input  logic                     req_type,
	input  logic [TAP_INDEX_W-1:0]   tap_index,
	input  logic                     rsp_valid,
	input  logic                     rsp_stall,
	output logic                     tap_we,
	output logic [$clog2(TAPS)-1:0]  tap_waddr,
	output logic [$clog2(TAPS)-1:0]  tap_raddr,
	output logic                     hist_we,
	output logic [$clog2(TAPS)-1:0]  hist_waddr,
	output logic [$clog2(TAPS)-1:0]  hist_raddr,
	output mac_ctl_t                 ctl
);

	localparam int AW = $clog2(TAPS);
	localparam int FW = $clog2(TAPS + 1);
	localparam int XW = (AW > TAP_INDEX_W) ? AW : TAP_INDEX_W;
	localparam logic [AW-1:0] LAST_TAP = AW'(TAPS - 1);

	seq_state_t      state_q, state_d;
	logic [AW-1:0]   k_q;
	logic [1:0]      drn_q;
	logic [AW-1:0]   wp_q;
	logic [AW-1:0]   hptr_q;
	logic [FW-1:0]   fill_q;
	logic            accept;
	logic            is_coef;
	logic            out_free;
	logic [XW-1:0]   idx_ext;

	assign accept   = req_valid && !req_stall;
	assign is_coef  = req_t'(req_type) == REQ_COEF;
	assign out_free = !rsp_valid || !rsp_stall;
	assign idx_ext  = XW'(tap_index);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && !is_coef) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (k_q == LAST_TAP) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (drn_q == 2'(DRAIN_CYCLES - 1)) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_stall     = state_q != ST_IDLE;
		tap_we        = accept && is_coef && (idx_ext < XW'(TAPS));
		tap_waddr     = idx_ext[AW-1:0];
		tap_raddr     = k_q;
		hist_we       = accept && !is_coef;
		hist_waddr    = wp_q;
		hist_raddr    = hptr_q;
		ctl.start     = accept && !is_coef;
		ctl.load      = (state_q == ST_LOAD) && out_free;
		ctl.valid     = state_q == ST_RUN;
		ctl.odd       = k_q[0];
		ctl.group_end = &k_q[GROUP_LOG-1:0];
		ctl.hist_ok   = FW'(k_q) < fill_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			drn_q   <= '0;
			wp_q    <= '0;
			hptr_q  <= '0;
			fill_q  <= '0;
		end else begin
			state_q <= state_d;
			if (accept && !is_coef) begin
				// newest sample lands at wp, the walk starts there going back in time
				hptr_q <= wp_q;
				wp_q   <= (wp_q == LAST_TAP) ? '0 : wp_q + 1'b1;
				k_q    <= '0;
				drn_q  <= '0;
				if (fill_q != FW'(TAPS)) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (state_q == ST_RUN) begin
				k_q    <= k_q + 1'b1;
				hptr_q <= (hptr_q == '0) ? LAST_TAP : hptr_q - 1'b1;
			end
			if (state_q == ST_DRAIN) begin
				drn_q <= drn_q + 1'b1;
			end
		end
	end

endmodule

@@ design/fgr_mac.sv @@
// ----------------------------------------------------------------------------
// fgr_mac
// Shared multiply-accumulate datapath: one 16x16 product per cycle, even/odd
// partial sums per group of eight, rounding and the output register.
// ----------------------------------------------------------------------------
module fgr_mac
	import fgr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  mac_ctl_t            ctl,
	input  logic [SAMPLE_W-1:0] tap_rdata,
	input  logic [SAMPLE_W-1:0] hist_rdata,
	input  logic                rsp_stall,
	output logic                rsp_valid,
	output logic [SAMPLE_W-1:0] sample_out
);

	mac_ctl_t         ctl_s1, ctl_s2, ctl_s3;
	logic [ACC_W-1:0] prod_s2;
	logic [ACC_W-1:0] even_q, odd_q;
	logic [ACC_W-1:0] rnd_e_q, rnd_o_q;
	logic [ACC_W-1:0] acc_q;
	logic [ACC_W-1:0] part_e, part_o;
	logic             rsp_valid_q;
	logic [SAMPLE_W-1:0] sample_out_q;

	assign part_e = ACC_W'($signed(rnd_e_q) >>> PART_SHIFT);
	assign part_o = ACC_W'($signed(rnd_o_q) >>> PART_SHIFT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1      <= '0;
			ctl_s2      <= '0;
			ctl_s3      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			ctl_s1 <= ctl;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			if (ctl.load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		// history entries not yet filled read as zero
		prod_s2 <= ctl_s1.hist_ok ?
			ACC_W'($signed(tap_rdata) * $signed(hist_rdata)) : '0;

		if (ctl.start) begin
			even_q <= '0;
			odd_q  <= '0;
		end else if (ctl_s2.valid) begin
			if (ctl_s2.group_end) begin
				rnd_e_q <= even_q + ROUND_ADD;
				rnd_o_q <= odd_q + prod_s2 + ROUND_ADD;
				even_q  <= '0;
				odd_q   <= '0;
			end else if (ctl_s2.odd) begin
				odd_q <= odd_q + prod_s2;
			end else begin
				even_q <= even_q + prod_s2;
			end
		end

		if (ctl.start) begin
			acc_q <= ACC_INIT;
		end else if (ctl_s3.valid && ctl_s3.group_end) begin
			acc_q <= acc_q + part_e + part_o;
		end

		if (ctl.load) begin
			sample_out_q <= acc_q[OUT_SHIFT +: SAMPLE_W];
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign sample_out = sample_out_q;

endmodule

@@ design/fir_grouped_round_filter.sv @@
// ----------------------------------------------------------------------------
// fir_grouped_round_filter
// FIR filter over signed 16-bit samples with 8*GROUPS loadable taps, summed
// in groups of eight with separately rounded even and odd partial sums.
// ----------------------------------------------------------------------------
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  req     | req_valid, req_stall, req_type, sample_in,     | in
//          | tap_index, tap_value                           |
//  rsp     | rsp_valid, rsp_stall, sample_out               | out
//
//  a coefficient write leaves the block ready
//  a sample runs one shared MAC pass over every tap, one product per
//  cycle, then a pipeline drain
//  a finished result waits in the output register while new transactions
//  are taken; a sample finishing behind a stalled result waits for it
//  reset clears the history fill count, taps are undefined until written
// ----------------------------------------------------------------------------
module fir_grouped_round_filter
	import fgr_pkg::*;
#(
	parameter int GROUPS = 62
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_stall,
	input  logic                   req_type,
	input  logic [SAMPLE_W-1:0]    sample_in,
	input  logic [TAP_INDEX_W-1:0] tap_index,
	input  logic [SAMPLE_W-1:0]    tap_value,
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	output logic [SAMPLE_W-1:0]    sample_out
);

	localparam int TAPS = 8 * GROUPS;
	localparam int AW   = $clog2(TAPS);

	mac_ctl_t            ctl;
	logic                tap_we, hist_we;
	logic [AW-1:0]       tap_waddr, tap_raddr, hist_waddr, hist_raddr;
	logic [SAMPLE_W-1:0] tap_rdata, hist_rdata;

	fgr_ctrl #(
		.TAPS(TAPS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_type   (req_type),
		.tap_index  (tap_index),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.tap_we     (tap_we),
		.tap_waddr  (tap_waddr),
		.tap_raddr  (tap_raddr),
		.hist_we    (hist_we),
		.hist_waddr (hist_waddr),
		.hist_raddr (hist_raddr),
		.ctl        (ctl)
	);

	fgr_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(TAPS)
	) u_tap_ram (
		.clk   (clk),
		.we    (tap_we),
		.waddr (tap_waddr),
		.wdata (tap_value),
		.raddr (tap_raddr),
		.rdata (tap_rdata)
	);

	// circular history, newest sample included
	fgr_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(TAPS)
	) u_hist_ram (
		.clk   (clk),
		.we    (hist_we),
		.waddr (hist_waddr),
		.wdata (sample_in),
		.raddr (hist_raddr),
		.rdata (hist_rdata)
	);

	fgr_mac u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.tap_rdata  (tap_rdata),
		.hist_rdata (hist_rdata),
		.rsp_stall  (rsp_stall),
		.rsp_valid  (rsp_valid),
		.sample_out (sample_out)
	);

endmodule

@@ design/fgr_checker.sv @@
// ----------------------------------------------------------------------------
// fgr_checker
// Port-level checks of the filter's transaction ordering.
// ----------------------------------------------------------------------------
module fgr_checker
	import fgr_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_stall,
	input logic                req_type,
	input logic                rsp_valid,
	input logic                rsp_stall,
	input logic [SAMPLE_W-1:0] sample_out
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(sample_out))
		else $error("stalled result changed");

	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req_type == REQ_SAMPLE |=> req_stall)
		else $error("sample transaction did not start a filter pass");

	a_coef_ready: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req_type == REQ_COEF |=> !req_stall)
		else $error("coefficient write left the block busy");

	// a new result only appears at the end of a filter pass
	a_rsp_from_pass: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("result appeared without a filter pass");

endmodule

bind fir_grouped_round_filter fgr_checker u_fgr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req_valid),
	.req_stall  (req_stall),
	.req_type   (req_type),
	.rsp_valid  (rsp_valid),
	.rsp_stall  (rsp_stall),
	.sample_out (sample_out)
);
